/* rtl/mcwd_pkg.sv */
// ----------------------------------------------------------------------------
// mcwd_pkg
// Shared constants for the microcode control word decoder: control signal
// bits, the common microinstruction words, the opcode-to-kind table, the
// per-kind microinstruction words and the conditional jump selector codes.
// ----------------------------------------------------------------------------
package mcwd_pkg;

  // Field widths
  localparam int unsigned FlagsWidth = 4;
  localparam int unsigned OpWidth    = 6;
  localparam int unsigned StepWidth  = 3;
  localparam int unsigned WordWidth  = 24;
  localparam int unsigned KindWidth  = 5;
  localparam int unsigned SelWidth   = 4;
  localparam int unsigned KindCount  = 29;
  localparam int unsigned SlotCount  = 4;
  localparam int unsigned OpCount    = 64;

  typedef logic [WordWidth-1:0] word_t;
  typedef logic [KindWidth-1:0] kind_t;

  // Flag bit positions
  localparam int unsigned FlagZ = 0;
  localparam int unsigned FlagC = 1;
  localparam int unsigned FlagV = 2;
  localparam int unsigned FlagN = 3;

  // Control signal bits
  localparam word_t S_HLT   = 24'h000001;
  localparam word_t S_CLR   = 24'h000002;
  localparam word_t S_OE    = 24'h000004;
  localparam word_t S_OUT1  = 24'h000008;
  localparam word_t S_OUT0  = 24'h000010;
  localparam word_t S_IOP2  = 24'h000020;
  localparam word_t S_IOP1  = 24'h000040;
  localparam word_t S_IOP0  = 24'h000080;
  localparam word_t S_MPG1  = 24'h000100;
  localparam word_t S_MPG0  = 24'h000200;
  localparam word_t S_LDREG = 24'h000400;
  localparam word_t S_LDTMP = 24'h000800;
  localparam word_t S_LDFLG = 24'h001000;
  localparam word_t S_ADRIN = 24'h002000;
  localparam word_t S_MEMIN = 24'h004000;
  localparam word_t S_IRIN  = 24'h008000;
  localparam word_t S_PCIN  = 24'h010000;
  localparam word_t S_PCPP  = 24'h020000;
  localparam word_t S_SPPP  = 24'h040000;
  localparam word_t S_DECIN = 24'h080000;
  localparam word_t S_LCDIN = 24'h100000;
  localparam word_t S_LCDDT = 24'h200000;
  localparam word_t S_INP   = 24'h400000;
  localparam word_t S_ACK   = 24'h800000;

  // Common microinstruction words
  localparam word_t W_FETCH0 = S_OE | S_OUT1 | S_ADRIN;
  localparam word_t W_FETCH1 = S_PCPP | S_OE | S_OUT0 | S_IRIN | S_LDTMP;
  localparam word_t W_ARG    = S_OE | S_OUT0 | S_MPG0;
  localparam word_t W_MOVA   = S_IOP2;
  localparam word_t W_MOVB   = S_IOP2 | S_IOP0;
  localparam word_t W_ANDI   = S_IOP2 | S_IOP1 | S_IOP0;
  localparam word_t W_STKMEM = S_MPG1 | S_MPG0;
  localparam word_t W_STKOUT = S_OUT1 | S_OUT0;
  localparam word_t W_JUMP   = W_ARG | S_PCIN | S_CLR;

  // Conditional jump range and kind
  localparam logic [OpWidth-1:0] CondFirst = 6'b101100;
  localparam logic [OpWidth-1:0] CondLast  = 6'b110111;
  localparam kind_t              KindCond  = 5'd20;

  // Microsteps with special meaning
  localparam logic [StepWidth-1:0] StepFetch0  = 3'd0;
  localparam logic [StepWidth-1:0] StepFetch1  = 3'd1;
  localparam logic [StepWidth-1:0] StepBody    = 3'd2;
  localparam logic [StepWidth-1:0] StepBodyEnd = 3'd5;

  // Jump condition selectors, in opcode order
  typedef enum logic [SelWidth-1:0] {
    COND_Z   = 4'd0,
    COND_NZ  = 4'd1,
    COND_C   = 4'd2,
    COND_NC  = 4'd3,
    COND_V   = 4'd4,
    COND_NV  = 4'd5,
    COND_N   = 4'd6,
    COND_P   = 4'd7,
    COND_GT0 = 4'd8,
    COND_ULE = 4'd9,
    COND_SLT = 4'd10,
    COND_SLE = 4'd11
  } cond_sel_e;

  // Instruction kind for each opcode
  localparam kind_t OPCODE_KIND [OpCount] = '{
    5'd0,  5'd0,  5'd0,  5'd0,  5'd1,  5'd1,  5'd1,  5'd1,
    5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd6,  5'd6,  5'd6,
    5'd7,  5'd7,  5'd7,  5'd7,  5'd8,  5'd9,  5'd10, 5'd11,
    5'd12, 5'd12, 5'd12, 5'd12, 5'd13, 5'd13, 5'd13, 5'd13,
    5'd14, 5'd14, 5'd14, 5'd14, 5'd15, 5'd15, 5'd15, 5'd15,
    5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd20, 5'd20, 5'd20,
    5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20,
    5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28
  };

  // Body words (steps 2 to 5) for each instruction kind
  localparam word_t KIND_WORDS [KindCount][SlotCount] = '{
    '{W_ARG | S_LDTMP, S_OE | S_LDREG | S_LDFLG | S_CLR, '0, '0},
    '{W_ARG | S_LDTMP | S_IOP2, S_OE | S_LDREG | S_IOP0 | S_LDFLG | S_CLR, '0, '0},
    '{W_ARG | S_LDTMP | S_LDFLG | S_CLR, '0, '0, '0},
    '{W_ARG | S_LDTMP | S_IOP2 | S_IOP1 | S_LDFLG | S_CLR, '0, '0, '0},
    '{W_ARG | S_LDTMP | W_ANDI | S_LDFLG | S_CLR, '0, '0, '0},
    '{S_INP | S_LDTMP | S_IOP2, '0, W_ARG | S_LDTMP | W_ANDI | S_LDFLG | S_CLR, '0},
    '{W_ARG | S_LDREG | S_CLR, '0, '0, '0},
    '{S_INP | S_LDREG, S_CLR, '0, '0},
    '{S_ACK | S_CLR, '0, '0, '0},
    '{W_ARG | S_ADRIN, S_OE | W_MOVB | S_MPG1 | S_MEMIN | S_CLR, '0, '0},
    '{W_ARG | S_LDTMP, S_OE | W_MOVB | S_ADRIN,
      S_OE | W_MOVA | S_MPG1 | S_MEMIN | S_CLR, '0},
    '{S_SPPP | S_IOP2, S_OE | W_STKOUT | S_ADRIN,
      S_OE | W_MOVB | W_STKMEM | S_MEMIN | S_CLR, '0},
    '{W_ARG | S_ADRIN, S_OE | S_OUT0 | S_MPG1 | S_LDREG | S_CLR, '0, '0},
    '{S_OE | W_MOVB | S_ADRIN, S_OE | S_OUT0 | S_MPG1 | S_LDREG | S_CLR, '0, '0},
    '{S_OE | W_STKOUT | S_ADRIN,
      S_OE | S_OUT0 | W_STKMEM | S_LDREG | S_SPPP | S_CLR, '0, '0},
    '{S_OE | W_STKOUT | S_ADRIN, S_OE | S_OUT0 | W_STKMEM | S_LDREG,
      S_OE | W_MOVB | W_STKMEM | S_MEMIN | S_CLR, '0},
    '{W_ARG | S_PCIN | S_CLR, '0, '0, '0},
    '{S_OE | W_MOVB | S_PCIN | S_CLR, '0, '0, '0},
    '{W_ARG | S_LDTMP | S_IOP2 | S_SPPP, S_OE | W_STKOUT | S_ADRIN,
      S_OE | S_OUT1 | W_STKMEM | S_MEMIN, S_OE | W_MOVB | S_PCIN | S_CLR},
    '{S_OE | W_STKOUT | S_ADRIN,
      S_OE | S_OUT0 | W_STKMEM | S_PCIN | S_SPPP | S_CLR, '0, '0},
    '{S_CLR, '0, '0, '0},
    '{W_ARG | S_LCDIN | S_CLR, '0, '0, '0},
    '{W_ARG | S_LCDIN | S_LCDDT | S_CLR, '0, '0, '0},
    '{S_OE | W_MOVB | S_LCDIN | S_LCDDT | S_CLR, '0, '0, '0},
    '{W_ARG | S_ADRIN, S_OE | S_OUT0 | S_MPG1 | S_LCDIN | S_LCDDT | S_CLR, '0, '0},
    '{S_OE | W_MOVB | S_DECIN | S_CLR, '0, '0, '0},
    '{W_ARG | S_ADRIN, S_OE | S_OUT0 | S_MPG1 | S_DECIN | S_CLR, '0, '0},
    '{S_HLT, '0, '0, '0},
    '{'0, '0, '0, '0}
  };

endpackage

/* rtl/microcode_control_word_decoder.sv */
// ----------------------------------------------------------------------------
// microcode_control_word_decoder
// Control store decoder for a small 8-bit CPU: flags, opcode and microstep
// in, 24-bit control word out.
//
//   Channel  Handshake          Fields
//   -------  -----------------  ----------------------------------------------
//   item in  start_i, busy_o    condition_flags_i, opcode_index_i, micro_step_i
//   result   done_o (strobe)    control_word_o
//
// One item per cycle. An accepted item is captured in the input register, its
// control word is registered at the next edge and shown with done_o for one
// cycle. busy_o stays low; the result strobe is a single cycle and the
// receiver cannot stall it. Reset clears both valid flags, so no result is
// shown until an item has been taken.
// ----------------------------------------------------------------------------
module microcode_control_word_decoder
  import mcwd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [FlagsWidth-1:0] condition_flags_i,
  input  logic [OpWidth-1:0]    opcode_index_i,
  input  logic [StepWidth-1:0]  micro_step_i,
  output logic                  done_o,
  output logic [WordWidth-1:0]  control_word_o
);

  logic                  in_valid_q;
  logic [FlagsWidth-1:0] flags_q;
  logic [OpWidth-1:0]    opcode_q;
  logic [StepWidth-1:0]  step_q;
  logic                  out_valid_q;
  word_t                 word_d;
  word_t                 word_q;
  logic                  accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Capture the incoming item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q  <= condition_flags_i;
      opcode_q <= opcode_index_i;
      step_q   <= micro_step_i;
    end
  end

  mcwd_decode u_decode (
    .flags_i  (flags_q),
    .opcode_i (opcode_q),
    .step_i   (step_q),
    .word_o   (word_d)
  );

  // Register the decoded word and its strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      word_q <= word_d;
    end
  end

  assign done_o         = out_valid_q;
  assign control_word_o = word_q;

endmodule

/* rtl/mcwd_cond.sv */
// ----------------------------------------------------------------------------
// mcwd_cond
// Jump condition evaluator: tests one of the twelve branch conditions
// against the zero, carry, overflow and sign flags.
// ----------------------------------------------------------------------------
module mcwd_cond
  import mcwd_pkg::*;
(
  input  logic [FlagsWidth-1:0] flags_i,
  input  logic [SelWidth-1:0]   sel_i,
  output logic                  holds_o
);

  logic z;
  logic c;
  logic v;
  logic n;

  assign z = flags_i[FlagZ];
  assign c = flags_i[FlagC];
  assign v = flags_i[FlagV];
  assign n = flags_i[FlagN];

  // Pick the condition named by the selector
  always_comb begin
    unique case (cond_sel_e'(sel_i))
      COND_Z:   holds_o = z;
      COND_NZ:  holds_o = !z;
      COND_C:   holds_o = c;
      COND_NC:  holds_o = !c;
      COND_V:   holds_o = v;
      COND_NV:  holds_o = !v;
      COND_N:   holds_o = n;
      COND_P:   holds_o = !n;
      COND_GT0: holds_o = !n && !z;
      COND_ULE: holds_o = z || c;
      COND_SLT: holds_o = v ^ n;
      COND_SLE: holds_o = (v ^ n) || z;
      default:  holds_o = 1'b0;
    endcase
  end

endmodule

/* rtl/mcwd_decode.sv */
// ----------------------------------------------------------------------------
// mcwd_decode
// Control store lookup: maps opcode and microstep to the control word,
// with the taken-jump override at the first body step of a conditional jump.
// ----------------------------------------------------------------------------
module mcwd_decode
  import mcwd_pkg::*;
(
  input  logic [FlagsWidth-1:0] flags_i,
  input  logic [OpWidth-1:0]    opcode_i,
  input  logic [StepWidth-1:0]  step_i,
  output word_t                 word_o
);

  kind_t                kind;
  logic [OpWidth-1:0]   cond_off;
  logic [StepWidth-1:0] slot_full;
  logic [1:0]           slot;
  logic                 is_cond;
  logic                 cond_holds;

  assign kind      = OPCODE_KIND[opcode_i];
  assign cond_off  = opcode_i - CondFirst;
  assign slot_full = step_i - StepBody;
  assign slot      = slot_full[1:0];
  assign is_cond   = (kind == KindCond);

  mcwd_cond u_cond (
    .flags_i (flags_i),
    .sel_i   (cond_off[SelWidth-1:0]),
    .holds_o (cond_holds)
  );

  // Select fetch, body or empty word by microstep
  always_comb begin
    if (step_i == StepFetch0) begin
      word_o = W_FETCH0;
    end else if (step_i == StepFetch1) begin
      word_o = W_FETCH1;
    end else if (step_i <= StepBodyEnd) begin
      if (is_cond && step_i == StepBody && cond_holds) begin
        word_o = W_JUMP;
      end else begin
        word_o = KIND_WORDS[kind][slot];
      end
    end else begin
      word_o = '0;
    end
  end

endmodule

/* rtl/mcwd_checker.sv */
// ----------------------------------------------------------------------------
// mcwd_checker
// Port-level checks for the control word decoder: result timing, the first
// fetch word, empty unused microsteps and the taken jump on zero.
// ----------------------------------------------------------------------------
module mcwd_checker
  import mcwd_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic [FlagsWidth-1:0] condition_flags_i,
  input logic [OpWidth-1:0]    opcode_index_i,
  input logic [StepWidth-1:0]  micro_step_i,
  input logic                  done_o,
  input logic [WordWidth-1:0]  control_word_o
);

  // Every accepted item yields a result through the input and output registers
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("accepted item produced no result");

  // No result strobe without a matching accepted item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result strobe without accepted item");

  // First microstep always gives the first fetch word
  a_fetch0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(micro_step_i, 2) == StepFetch0) |-> control_word_o == W_FETCH0)
    else $error("wrong first fetch word");

  // Steps past the body are empty
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(micro_step_i, 2) > StepBodyEnd) |-> control_word_o == '0)
    else $error("unused microstep not zero");

  // Jump on zero is taken at the first body step when the zero flag is set
  a_jump_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(opcode_index_i, 2) == CondFirst &&
     $past(micro_step_i, 2) == StepBody &&
     $past(condition_flags_i[FlagZ], 2)) |-> control_word_o == W_JUMP)
    else $error("jump on zero not taken");

endmodule

bind microcode_control_word_decoder mcwd_checker u_mcwd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .condition_flags_i (condition_flags_i),
  .opcode_index_i    (opcode_index_i),
  .micro_step_i      (micro_step_i),
  .done_o            (done_o),
  .control_word_o    (control_word_o)
);

/* tb/sv/microcode_control_word_decoder_tb.sv */
// ----------------------------------------------------------------------------
// microcode_control_word_decoder_tb
// Self-checking testbench for the control store decoder. A directed table
// covers the fetch words, unused steps, HALT, NOP and every jump condition,
// some on both outcomes. Random instruction walks and loose items follow.
// The sender works in bursts with random gaps. Each control word is compared
// with its row's fixed word or an independent decode of the control store.
// ----------------------------------------------------------------------------
module microcode_control_word_decoder_tb
  import mcwd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 600;
  localparam int unsigned IdleLimit   = 500;
  localparam int unsigned TailCycles  = 8;

  // Opcodes used by name in the directed table
  localparam logic [OpWidth-1:0] OpAluFirst = 6'd0;
  localparam logic [OpWidth-1:0] OpInTest   = 6'd11;
  localparam logic [OpWidth-1:0] OpCall     = 6'd42;
  localparam logic [OpWidth-1:0] OpHalt     = 6'd62;
  localparam logic [OpWidth-1:0] OpNop      = 6'd63;

  typedef logic [SlotCount-1:0][WordWidth-1:0] body_t;

  // Instruction groups sharing one microprogram body
  typedef enum logic [4:0] {
    G_ALU_ARG, G_ALU_ARG_B, G_CMP_ARG, G_OR_ARG, G_AND_ARG, G_IN_AND,
    G_LOAD_IMM, G_IN_REG, G_ACK, G_STORE_ADR, G_STORE_IND, G_PUSH,
    G_LOAD_ADR, G_LOAD_IND, G_POP, G_POP_STORE, G_JMP, G_JMP_REG, G_CALL,
    G_RET, G_JCOND, G_LCD_CMD, G_LCD_DATA, G_LCD_REG, G_LCD_MEM,
    G_DEC_REG, G_DEC_MEM, G_HALT, G_NOP
  } group_e;

  typedef struct packed {
    logic [FlagsWidth-1:0] flags;
    logic [OpWidth-1:0]    op;
    logic [StepWidth-1:0]  step;
    logic                  fixed;
    word_t                 word;
  } probe_t;

  group_e op_group [OpCount] = '{
    G_ALU_ARG, G_ALU_ARG, G_ALU_ARG, G_ALU_ARG,
    G_ALU_ARG_B, G_ALU_ARG_B, G_ALU_ARG_B, G_ALU_ARG_B,
    G_CMP_ARG, G_OR_ARG, G_AND_ARG, G_IN_AND,
    G_LOAD_IMM, G_LOAD_IMM, G_LOAD_IMM, G_LOAD_IMM,
    G_IN_REG, G_IN_REG, G_IN_REG, G_IN_REG,
    G_ACK, G_STORE_ADR, G_STORE_IND, G_PUSH,
    G_LOAD_ADR, G_LOAD_ADR, G_LOAD_ADR, G_LOAD_ADR,
    G_LOAD_IND, G_LOAD_IND, G_LOAD_IND, G_LOAD_IND,
    G_POP, G_POP, G_POP, G_POP,
    G_POP_STORE, G_POP_STORE, G_POP_STORE, G_POP_STORE,
    G_JMP, G_JMP_REG, G_CALL, G_RET,
    G_JCOND, G_JCOND, G_JCOND, G_JCOND, G_JCOND, G_JCOND,
    G_JCOND, G_JCOND, G_JCOND, G_JCOND, G_JCOND, G_JCOND,
    G_LCD_CMD, G_LCD_DATA, G_LCD_REG, G_LCD_MEM,
    G_DEC_REG, G_DEC_MEM, G_HALT, G_NOP
  };

  // Directed rows: a fixed word stands where it is plain from the spec
  probe_t directed_rows [24] = '{
    '{4'b0000, OpAluFirst, StepFetch0, 1'b1, W_FETCH0},
    '{4'b1111, OpNop, StepFetch1, 1'b1, W_FETCH1},
    '{4'b1111, OpNop, StepBody, 1'b1, '0},
    '{4'b0000, OpHalt, StepBody, 1'b1, S_HLT},
    '{4'b1111, OpNop, 3'd7, 1'b1, '0},
    '{4'b0000, OpAluFirst, 3'd6, 1'b1, '0},
    '{4'b1010, OpCall, StepBodyEnd, 1'b0, '0},
    '{4'b0101, OpInTest, 3'd4, 1'b0, '0},
    '{4'b0001, 6'(CondFirst + COND_Z), StepBody, 1'b1, W_JUMP},
    '{4'b0000, 6'(CondFirst + COND_Z), StepBody, 1'b1, S_CLR},
    '{4'b0000, 6'(CondFirst + COND_NZ), StepBody, 1'b1, W_JUMP},
    '{4'b0010, 6'(CondFirst + COND_C), StepBody, 1'b1, W_JUMP},
    '{4'b1111, 6'(CondFirst + COND_NC), StepBody, 1'b1, S_CLR},
    '{4'b0100, 6'(CondFirst + COND_V), StepBody, 1'b1, W_JUMP},
    '{4'b0100, 6'(CondFirst + COND_NV), StepBody, 1'b1, S_CLR},
    '{4'b1000, 6'(CondFirst + COND_N), StepBody, 1'b1, W_JUMP},
    '{4'b1000, 6'(CondFirst + COND_P), StepBody, 1'b1, S_CLR},
    '{4'b0000, 6'(CondFirst + COND_GT0), StepBody, 1'b1, W_JUMP},
    '{4'b0001, 6'(CondFirst + COND_GT0), StepBody, 1'b1, S_CLR},
    '{4'b0010, 6'(CondFirst + COND_ULE), StepBody, 1'b1, W_JUMP},
    '{4'b0100, 6'(CondFirst + COND_SLT), StepBody, 1'b1, W_JUMP},
    '{4'b1100, 6'(CondFirst + COND_SLT), StepBody, 1'b1, S_CLR},
    '{4'b1101, 6'(CondFirst + COND_SLE), StepBody, 1'b1, W_JUMP},
    '{4'b1111, CondLast, 3'd3, 1'b1, '0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [FlagsWidth-1:0] condition_flags_i;
  logic [OpWidth-1:0]    opcode_index_i;
  logic [StepWidth-1:0]  micro_step_i;
  logic                  done_o;
  logic [WordWidth-1:0]  control_word_o;

  // Fixed expectation travelling with a directed item
  logic  row_fixed;
  word_t row_word;

  word_t       pending_words [$];
  word_t       oldest_word;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned words_checked;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned jumps_taken;
  int unsigned jumps_skipped;
  logic [OpCount*8-1:0] pair_seen;

  microcode_control_word_decoder uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .condition_flags_i (condition_flags_i),
    .opcode_index_i    (opcode_index_i),
    .micro_step_i      (micro_step_i),
    .done_o            (done_o),
    .control_word_o    (control_word_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Decide whether a conditional jump is taken on the given flags
  function automatic logic jump_condition_met(input cond_sel_e sel,
                                              input logic [FlagsWidth-1:0] f);
    logic z, c, v, n;
    z = f[FlagZ];
    c = f[FlagC];
    v = f[FlagV];
    n = f[FlagN];
    case (sel)
      COND_Z:   return z;
      COND_NZ:  return !z;
      COND_C:   return c;
      COND_NC:  return !c;
      COND_V:   return v;
      COND_NV:  return !v;
      COND_N:   return n;
      COND_P:   return !n;
      COND_GT0: return !n && !z;
      COND_ULE: return z || c;
      COND_SLT: return v ^ n;
      COND_SLE: return (v ^ n) || z;
      default:  return 1'b0;
    endcase
  endfunction

  // Body words for steps 2 to 5 of an opcode
  function automatic body_t body_words(input logic [OpWidth-1:0] op);
    body_t b;
    b = '0;
    case (op_group[op])
      G_ALU_ARG: begin
        b[0] = W_ARG | S_LDTMP;
        b[1] = S_OE | S_LDREG | S_LDFLG | S_CLR;
      end
      G_ALU_ARG_B: begin
        b[0] = W_ARG | S_LDTMP | S_IOP2;
        b[1] = S_OE | S_LDREG | S_IOP0 | S_LDFLG | S_CLR;
      end
      G_CMP_ARG: b[0] = W_ARG | S_LDTMP | S_LDFLG | S_CLR;
      G_OR_ARG:  b[0] = W_ARG | S_LDTMP | S_IOP2 | S_IOP1 | S_LDFLG | S_CLR;
      G_AND_ARG: b[0] = W_ARG | S_LDTMP | W_ANDI | S_LDFLG | S_CLR;
      G_IN_AND: begin
        b[0] = S_INP | S_LDTMP | S_IOP2;
        b[2] = W_ARG | S_LDTMP | W_ANDI | S_LDFLG | S_CLR;
      end
      G_LOAD_IMM: b[0] = W_ARG | S_LDREG | S_CLR;
      G_IN_REG: begin
        b[0] = S_INP | S_LDREG;
        b[1] = S_CLR;
      end
      G_ACK: b[0] = S_ACK | S_CLR;
      G_STORE_ADR: begin
        b[0] = W_ARG | S_ADRIN;
        b[1] = S_OE | W_MOVB | S_MPG1 | S_MEMIN | S_CLR;
      end
      G_STORE_IND: begin
        b[0] = W_ARG | S_LDTMP;
        b[1] = S_OE | W_MOVB | S_ADRIN;
        b[2] = S_OE | W_MOVA | S_MPG1 | S_MEMIN | S_CLR;
      end
      G_PUSH: begin
        b[0] = S_SPPP | S_IOP2;
        b[1] = S_OE | W_STKOUT | S_ADRIN;
        b[2] = S_OE | W_MOVB | W_STKMEM | S_MEMIN | S_CLR;
      end
      G_LOAD_ADR: begin
        b[0] = W_ARG | S_ADRIN;
        b[1] = S_OE | S_OUT0 | S_MPG1 | S_LDREG | S_CLR;
      end
      G_LOAD_IND: begin
        b[0] = S_OE | W_MOVB | S_ADRIN;
        b[1] = S_OE | S_OUT0 | S_MPG1 | S_LDREG | S_CLR;
      end
      G_POP: begin
        b[0] = S_OE | W_STKOUT | S_ADRIN;
        b[1] = S_OE | S_OUT0 | W_STKMEM | S_LDREG | S_SPPP | S_CLR;
      end
      G_POP_STORE: begin
        b[0] = S_OE | W_STKOUT | S_ADRIN;
        b[1] = S_OE | S_OUT0 | W_STKMEM | S_LDREG;
        b[2] = S_OE | W_MOVB | W_STKMEM | S_MEMIN | S_CLR;
      end
      G_JMP:     b[0] = W_ARG | S_PCIN | S_CLR;
      G_JMP_REG: b[0] = S_OE | W_MOVB | S_PCIN | S_CLR;
      G_CALL: begin
        b[0] = W_ARG | S_LDTMP | S_IOP2 | S_SPPP;
        b[1] = S_OE | W_STKOUT | S_ADRIN;
        b[2] = S_OE | S_OUT1 | W_STKMEM | S_MEMIN;
        b[3] = S_OE | W_MOVB | S_PCIN | S_CLR;
      end
      G_RET: begin
        b[0] = S_OE | W_STKOUT | S_ADRIN;
        b[1] = S_OE | S_OUT0 | W_STKMEM | S_PCIN | S_SPPP | S_CLR;
      end
      G_JCOND:    b[0] = S_CLR;
      G_LCD_CMD:  b[0] = W_ARG | S_LCDIN | S_CLR;
      G_LCD_DATA: b[0] = W_ARG | S_LCDIN | S_LCDDT | S_CLR;
      G_LCD_REG:  b[0] = S_OE | W_MOVB | S_LCDIN | S_LCDDT | S_CLR;
      G_LCD_MEM: begin
        b[0] = W_ARG | S_ADRIN;
        b[1] = S_OE | S_OUT0 | S_MPG1 | S_LCDIN | S_LCDDT | S_CLR;
      end
      G_DEC_REG: b[0] = S_OE | W_MOVB | S_DECIN | S_CLR;
      G_DEC_MEM: begin
        b[0] = W_ARG | S_ADRIN;
        b[1] = S_OE | S_OUT0 | S_MPG1 | S_DECIN | S_CLR;
      end
      G_HALT:  b[0] = S_HLT;
      default: b = '0;
    endcase
    return b;
  endfunction

  // Work out the control word for one flags/opcode/step triple
  function automatic word_t control_word_for(input logic [FlagsWidth-1:0] flags,
                                             input logic [OpWidth-1:0] op,
                                             input logic [StepWidth-1:0] step);
    body_t b;
    word_t w;
    if (step == StepFetch0) begin
      w = W_FETCH0;
    end else if (step == StepFetch1) begin
      w = W_FETCH1;
    end else if (step <= StepBodyEnd) begin
      b = body_words(op);
      w = b[2'(step - StepBody)];
      if (op_group[op] == G_JCOND && step == StepBody &&
          jump_condition_met(cond_sel_e'(SelWidth'(op - CondFirst)), flags)) begin
        w = W_ARG | S_PCIN | S_CLR;
      end
    end else begin
      w = '0;
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("[%0t] MISMATCH %s: got %06h, want %06h", $time, what, got, want);
    error_count++;
  endtask

  // Hand one item to the block, opening a new burst after a random gap
  task automatic issue(input logic [FlagsWidth-1:0] f, input logic [OpWidth-1:0] o,
                       input logic [StepWidth-1:0] s, input logic fixed,
                       input word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start_i           <= 1'b0;
        condition_flags_i <= FlagsWidth'($urandom);
        opcode_index_i    <= OpWidth'($urandom);
        micro_step_i      <= StepWidth'($urandom);
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
    start_i           <= 1'b1;
    condition_flags_i <= f;
    opcode_index_i    <= o;
    micro_step_i      <= s;
    row_fixed         <= fixed;
    row_word          <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // Hold off the sender until every expected word has come back
  task automatic drain_results();
    start_i    <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // Predict on acceptance, check on the result strobe
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        pending_words.push_back(row_fixed ? row_word
            : control_word_for(condition_flags_i, opcode_index_i, micro_step_i));
        pair_seen[{opcode_index_i, micro_step_i}] = 1'b1;
        if (op_group[opcode_index_i] == G_JCOND && micro_step_i == StepBody) begin
          if (jump_condition_met(cond_sel_e'(SelWidth'(opcode_index_i - CondFirst)),
                                 condition_flags_i)) begin
            jumps_taken++;
          end else begin
            jumps_skipped++;
          end
        end
      end
      if (done_o) begin
        if (pending_words.size() == 0) begin
          report_mismatch("unexpected result", control_word_o, '0);
        end else begin
          oldest_word = pending_words.pop_front();
          words_checked++;
          if (control_word_o !== oldest_word) begin
            report_mismatch("control_word", control_word_o, oldest_word);
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Watchdog: no progress for %0d cycles", IdleLimit);
        $display("microcode_control_word_decoder regression: fail");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    logic [FlagsWidth-1:0] f;
    logic [OpWidth-1:0]    o;
    int unsigned           last_step;
    int unsigned           random_sent;
    logic                  halfway_done;

    rst_ni            = 1'b0;
    start_i           = 1'b0;
    condition_flags_i = '0;
    opcode_index_i    = '0;
    micro_step_i      = '0;
    row_fixed         = 1'b0;
    row_word          = '0;
    error_count       = 0;
    items_sent        = 0;
    words_checked     = 0;
    burst_left        = 0;
    idle_cycles       = 0;
    jumps_taken       = 0;
    jumps_skipped     = 0;
    pair_seen         = '0;
    random_sent       = 0;
    halfway_done      = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed rows
    foreach (directed_rows[i]) begin
      issue(directed_rows[i].flags, directed_rows[i].op, directed_rows[i].step,
            directed_rows[i].fixed, directed_rows[i].word);
    end
    drain_results();

    // Mostly whole instruction walks, some loose items
    while (random_sent < RandomItems) begin
      if ($urandom_range(0, 9) < 8) begin
        f         = FlagsWidth'($urandom);
        o         = OpWidth'($urandom);
        last_step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 7;
        for (int s = 0; s <= last_step; s++) begin
          issue(f, o, StepWidth'(s), 1'b0, '0);
          random_sent++;
        end
      end else begin
        issue(FlagsWidth'($urandom), OpWidth'($urandom), StepWidth'($urandom),
              1'b0, '0);
        random_sent++;
      end
      if (!halfway_done && random_sent >= RandomItems / 2) begin
        drain_results();
        halfway_done = 1'b1;
      end
    end

    // Wait out the pipeline and finish
    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d items, checked %0d control words, %0d of %0d opcode/step pairs hit",
             items_sent, words_checked, $countones(pair_seen), OpCount * 8);
    $display("Conditional jumps at the body step: %0d taken, %0d not taken",
             jumps_taken, jumps_skipped);
    if (error_count == 0) begin
      $display("microcode_control_word_decoder regression: pass");
    end else begin
      $display("microcode_control_word_decoder regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mcwd_pkg.sv
rtl/mcwd_cond.sv
rtl/mcwd_decode.sv
rtl/microcode_control_word_decoder.sv
rtl/mcwd_checker.sv
tb/sv/microcode_control_word_decoder_tb.sv
